@@ rtl/cgsf_pkg.sv @@
// Shared constants, codes and the helper function of the cave grid smoothing filter.
`default_nettype none

package cgsf_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 1024;

  // Configuration port layout and register indexes.
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WALL_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_TO_WALL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 2'd3;

  localparam logic [3:0]            RST_WALL_LIMIT    = 4'd4;
  localparam logic                  RST_EMPTY_TO_WALL = 1'b1;
  localparam logic [CFG_DATA_W-1:0] RST_GRID_WIDTH    = 11'd64;
  localparam logic [CFG_DATA_W-1:0] RST_GRID_HEIGHT   = 11'd64;

  localparam int MIN_SIZE = 3;

  // Input word kinds carried on tuser.
  localparam logic REQ_CELL    = 1'b0;
  localparam logic REQ_PADDING = 1'b1;

  // Number of set bits in a 3x3 window.
  function automatic logic [3:0] popcount9(input logic [8:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cave_grid_smoothing_filter.sv @@
// Top level of the cave grid smoothing filter: line memory, 3x3 window and output skid stage.
`default_nettype none

// One smoothing pass over a binary wall/floor grid streamed in raster order.
// The block takes one input word per clock while it runs and its skid entry
// is empty. The two line buffers share one two-bit-wide memory, read ahead
// of the word that needs it and written back in the cycle that word is
// accepted. The result for a cell leaves grid_width+1 words after that cell
// enters; grid_width+1 padding words after the frame drain the last results.
// A two-entry output stage catches a result made while the downstream side
// stalls; input is held off while its skid entry is full. After reset and
// after every configuration write the input is held off while a settle state
// lets the derived size registers settle, then a radix-2 divider rebuilds
// the output row and column from the stream position. No input word is
// taken in a cycle that carries a configuration write.
module cave_grid_smoothing_filter
  import cgsf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input words.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [0] cell_is_wall, [7:1] zero
  input  wire logic [0:0]            in_tuser,   // [0] req_type
  // Result words.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,  // [0] out_is_wall, [7:1] zero
  output logic                       out_tlast,  // frame_last
  // Configuration writes.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int WH  = $clog2(MAX_HEIGHT + 1);
  localparam int SPW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
  localparam int DCW = $clog2(SPW);
  localparam int RW  = WW + 1;

  typedef enum logic [2:0] {
    S_RUN    = 3'b001,
    S_SETTLE = 3'b010,
    S_DIV    = 3'b100
  } state_t;

  // Configuration registers.
  logic [3:0]            wall_limit_r;
  logic                  empty_to_wall_r;
  logic [CFG_DATA_W-1:0] grid_width_r;
  logic [CFG_DATA_W-1:0] grid_height_r;

  // Derived sizes.
  logic [WW-1:0]  w_c;
  logic [WH-1:0]  h_c;
  logic [WW-1:0]  w_r;
  logic [WH-1:0]  h_r;
  logic [SPW-1:0] wp1_r;
  logic [SPW-1:0] total_r;
  logic [SPW-1:0] lastpos_r;
  logic [WW-1:0]  wm2_r;
  logic [WH-1:0]  hm2_r;

  // Stream state.
  state_t         state_r;
  logic [1:0]     settle_r;
  logic [CW-1:0]  col_r;
  logic [SPW-1:0] sp_r;
  logic [SPW-1:0] orow_r;
  logic [CW-1:0]  ocol_r;
  logic [8:0]     window_r;

  // Divider.
  logic [SPW-1:0] quo_r;
  logic [RW-1:0]  rem_r;
  logic [DCW-1:0] div_cnt_r;
  logic [RW-1:0]  div_shift;
  logic           div_bit;
  logic [RW-1:0]  rem_nxt;
  logic [SPW-1:0] quo_nxt;
  logic [SPW-1:0] dividend;

  // Line memory: bit 1 holds the upper row, bit 0 the middle row.
  logic [1:0]     line_mem [MAX_WIDTH];
  logic [1:0]     rd_data_r;
  logic [1:0]     fwd_data_r;
  logic           fwd_r;
  logic [1:0]     rd_val;
  logic [CW-1:0]  rd_addr;

  // Datapath.
  logic           acc;
  logic           cell_bit;
  logic [CW-1:0]  ec;
  logic [CW:0]    col_inc;
  logic [CW-1:0]  col_after;
  logic [2:0]     newcol;
  logic [8:0]     win_nxt;
  logic           has_res;
  logic           is_last;
  logic           restart;
  logic           interior;
  logic [3:0]     wall_cnt;
  logic           res_wall;
  logic [CW:0]    ocol_inc;

  // Output skid stage.
  logic           out_v_r;
  logic           out_wall_r;
  logic           out_last_r;
  logic           skid_v_r;
  logic           skid_wall_r;
  logic           skid_last_r;
  logic           produce;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_limit_r    <= RST_WALL_LIMIT;
      empty_to_wall_r <= RST_EMPTY_TO_WALL;
      grid_width_r    <= RST_GRID_WIDTH;
      grid_height_r   <= RST_GRID_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WALL_LIMIT:    wall_limit_r    <= cfg_data[3:0];
        REG_EMPTY_TO_WALL: empty_to_wall_r <= cfg_data[0];
        REG_GRID_WIDTH:    grid_width_r    <= cfg_data;
        REG_GRID_HEIGHT:   grid_height_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(grid_width_r) < 32'(MIN_SIZE)) begin
      w_c = WW'(MIN_SIZE);
    end else if (32'(grid_width_r) > 32'(MAX_WIDTH)) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(grid_width_r);
    end
    if (32'(grid_height_r) < 32'(MIN_SIZE)) begin
      h_c = WH'(MIN_SIZE);
    end else if (32'(grid_height_r) > 32'(MAX_HEIGHT)) begin
      h_c = WH'(MAX_HEIGHT);
    end else begin
      h_c = WH'(grid_height_r);
    end
  end

  // Derived sizes trail the configuration registers through w_r/h_r, then
  // wp1_r, total_r, wm2_r and hm2_r, then lastpos_r; the settle state covers that.
  always_ff @(posedge clk) begin
    w_r       <= w_c;
    h_r       <= h_c;
    wp1_r     <= SPW'(w_r) + SPW'(1);
    total_r   <= SPW'(w_r) * SPW'(h_r);
    wm2_r     <= w_r - WW'(2);
    hm2_r     <= h_r - WH'(2);
    lastpos_r <= total_r + SPW'(w_r);
  end

  assign acc       = in_tvalid && in_tready;
  assign in_tready = (state_r == S_RUN) && !skid_v_r && !cfg_valid;
  assign cell_bit  = (in_tuser[0] == REQ_CELL) ? in_tdata[0] : 1'b0;

  // A column left beyond a narrowed row restarts at zero.
  assign ec        = (32'(col_r) >= 32'(w_r)) ? '0 : col_r;
  assign col_inc   = {1'b0, ec} + (CW+1)'(1);
  assign col_after = (32'(col_inc) >= 32'(w_r)) ? '0 : col_inc[CW-1:0];

  assign rd_val  = fwd_r ? fwd_data_r : rd_data_r;
  assign newcol  = {cell_bit, rd_val[0], rd_val[1]};
  assign win_nxt = {newcol, window_r[8:3]};

  assign has_res = sp_r >= wp1_r;
  assign is_last = sp_r >= lastpos_r;
  assign restart = acc && has_res && is_last;
  assign produce = acc && has_res;

  assign interior = (orow_r != '0) && (32'(orow_r) <= 32'(hm2_r)) &&
                    (ocol_r != '0) && (32'(ocol_r) <= 32'(wm2_r));
  assign wall_cnt = popcount9(win_nxt);
  assign res_wall = interior ? ((wall_cnt > wall_limit_r) ||
                                (empty_to_wall_r && (wall_cnt == 4'd0)))
                             : win_nxt[4];

  // The next word's column is always known, so its read is issued before that word arrives.
  assign rd_addr = acc ? (restart ? '0 : col_after) : ec;

  always_ff @(posedge clk) begin
    if (acc) begin
      line_mem[ec] <= {rd_val[0], cell_bit};
    end
    rd_data_r  <= line_mem[rd_addr];
    fwd_data_r <= {rd_val[0], cell_bit};
  end

  // Forward a write that lands on the address read in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= acc && (rd_addr == ec);
    end
  end

  assign ocol_inc = {1'b0, ocol_r} + (CW+1)'(1);

  assign dividend  = has_res ? (sp_r - wp1_r) : '0;
  assign div_shift = {rem_r[RW-2:0], quo_r[SPW-1]};
  assign div_bit   = div_shift >= {1'b0, w_r};
  assign rem_nxt   = div_bit ? (div_shift - {1'b0, w_r}) : div_shift;
  assign quo_nxt   = {quo_r[SPW-2:0], div_bit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_SETTLE;
      settle_r  <= '0;
      col_r     <= '0;
      sp_r      <= '0;
      orow_r    <= '0;
      ocol_r    <= '0;
      window_r  <= '0;
      div_cnt_r <= '0;
    end else if (cfg_valid) begin
      state_r  <= S_SETTLE;
      settle_r <= '0;
    end else begin
      unique case (state_r)
        S_SETTLE: begin
          settle_r <= settle_r + 2'd1;
          if (settle_r == 2'd2) begin
            state_r   <= S_DIV;
            div_cnt_r <= DCW'(SPW - 1);
          end
        end
        S_DIV: begin
          div_cnt_r <= div_cnt_r - DCW'(1);
          if (div_cnt_r == '0) begin
            state_r <= S_RUN;
            orow_r  <= quo_nxt;
            ocol_r  <= rem_nxt[CW-1:0];
          end
        end
        S_RUN: begin
          if (restart) begin
            col_r    <= '0;
            sp_r     <= '0;
            orow_r   <= '0;
            ocol_r   <= '0;
            window_r <= '0;
          end else if (acc) begin
            col_r    <= col_after;
            sp_r     <= sp_r + SPW'(1);
            window_r <= win_nxt;
            if (has_res) begin
              if (32'(ocol_inc) >= 32'(w_r)) begin
                ocol_r <= '0;
                orow_r <= orow_r + SPW'(1);
              end else begin
                ocol_r <= ocol_inc[CW-1:0];
              end
            end
          end
        end
        default: state_r <= S_SETTLE;
      endcase
    end
  end

  // Divider operands load as the settle state ends.
  always_ff @(posedge clk) begin
    if (state_r == S_SETTLE) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Output register with one skid entry; on the output side, input stops only
  // while the skid entry is full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      if (produce) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_tready) begin
      if (produce) begin
        skid_wall_r <= res_wall;
        skid_last_r <= is_last;
      end
    end else if (skid_v_r) begin
      out_wall_r <= skid_wall_r;
      out_last_r <= skid_last_r;
    end else if (produce) begin
      out_wall_r <= res_wall;
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b000_0000, out_wall_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ verif/cave_grid_smoothing_filter_test.sv @@
// Self-checking testbench for the cave grid smoothing filter: directed frames, then random ones.
module cave_grid_smoothing_filter_test;
  import cgsf_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 480;
  localparam int LIMIT_CYCLES = 500000;
  localparam int SEED_ROWS    = 26;

  typedef struct packed {
    logic wall;
    logic last;
  } cell_result_t;

  typedef enum logic [1:0] {CHK_NONE, CHK_TYPED, CHK_PREDICTED} row_check_t;

  typedef struct packed {
    logic         kind;
    logic         wall;
    row_check_t   chk;
    cell_result_t want;
  } seed_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;   // [0] cell_is_wall, [7:1] zero
  logic [0:0]            in_tuser   = '0;   // [0] req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;         // [0] out_is_wall, [7:1] zero
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  cave_grid_smoothing_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor state: two line buffers, the 3x3 window and the stream counters.
  logic                  up_row  [DEFAULT_MAX_WIDTH];
  logic                  mid_row [DEFAULT_MAX_WIDTH];
  logic [8:0]            nbhd;
  int unsigned           col_pos;
  int unsigned           feed_pos;
  logic [3:0]            limit_reg;
  logic                  empty_wall_reg;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  bit                    frame_closed;

  cell_result_t smoothed_due[$];
  cell_result_t head_cell;
  int           mismatches = 0;
  int           words_fed  = 0;
  int           burst_left = 0;
  int unsigned  stall_tick = 0;
  int unsigned  stall_mode = 0;

  // Frame A is all wall, frame B all floor; B is drained with wall cells that must be ignored.
  seed_row_t seed_rows [0:SEED_ROWS-1] = '{
    '{REQ_CELL,    1'b1, CHK_NONE,      '{1'b0, 1'b0}}, '{REQ_CELL, 1'b1, CHK_NONE, '{1'b0, 1'b0}},
    '{REQ_CELL,    1'b1, CHK_NONE,      '{1'b0, 1'b0}}, '{REQ_CELL, 1'b1, CHK_NONE, '{1'b0, 1'b0}},
    '{REQ_CELL,    1'b1, CHK_TYPED,     '{1'b1, 1'b0}},
    '{REQ_CELL,    1'b1, CHK_TYPED,     '{1'b1, 1'b0}},
    '{REQ_CELL,    1'b1, CHK_TYPED,     '{1'b1, 1'b0}},
    '{REQ_CELL,    1'b1, CHK_TYPED,     '{1'b1, 1'b0}},
    '{REQ_CELL,    1'b1, CHK_TYPED,     '{1'b1, 1'b0}},
    '{REQ_PADDING, 1'b0, CHK_TYPED,     '{1'b1, 1'b0}},
    '{REQ_PADDING, 1'b0, CHK_TYPED,     '{1'b1, 1'b0}},
    '{REQ_PADDING, 1'b0, CHK_TYPED,     '{1'b1, 1'b0}},
    '{REQ_PADDING, 1'b0, CHK_TYPED,     '{1'b1, 1'b1}},
    '{REQ_CELL,    1'b0, CHK_NONE,      '{1'b0, 1'b0}}, '{REQ_CELL, 1'b0, CHK_NONE, '{1'b0, 1'b0}},
    '{REQ_CELL,    1'b0, CHK_NONE,      '{1'b0, 1'b0}}, '{REQ_CELL, 1'b0, CHK_NONE, '{1'b0, 1'b0}},
    '{REQ_CELL,    1'b0, CHK_TYPED,     '{1'b0, 1'b0}},
    '{REQ_CELL,    1'b0, CHK_TYPED,     '{1'b0, 1'b0}},
    '{REQ_CELL,    1'b0, CHK_TYPED,     '{1'b0, 1'b0}},
    '{REQ_CELL,    1'b0, CHK_TYPED,     '{1'b0, 1'b0}},
    '{REQ_CELL,    1'b0, CHK_TYPED,     '{1'b1, 1'b0}},
    '{REQ_CELL,    1'b1, CHK_PREDICTED, '{1'b0, 1'b0}},
    '{REQ_CELL,    1'b1, CHK_PREDICTED, '{1'b0, 1'b0}},
    '{REQ_CELL,    1'b1, CHK_PREDICTED, '{1'b0, 1'b0}},
    '{REQ_CELL,    1'b1, CHK_PREDICTED, '{1'b0, 1'b0}}
  };

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Advances the predicted window by one word; returns 1 when the word releases a result.
  function automatic bit smooth_step(input logic kind, input logic wall,
                                     output cell_result_t res);
    int unsigned w, h, idx, orow, ocol, cnt;
    logic        b;
    w   = clamp_dim(width_reg, DEFAULT_MAX_WIDTH);
    h   = clamp_dim(height_reg, DEFAULT_MAX_HEIGHT);
    b   = (kind == REQ_CELL) ? wall : 1'b0;
    res = '0;
    if (col_pos >= w) col_pos = 0;
    nbhd = {b, mid_row[col_pos], up_row[col_pos], nbhd[8:3]};
    up_row[col_pos]  = mid_row[col_pos];
    mid_row[col_pos] = b;
    col_pos++;
    if (col_pos >= w) col_pos = 0;
    if (feed_pos < w + 1) begin
      feed_pos++;
      return 1'b0;
    end
    idx  = feed_pos - (w + 1);
    orow = idx / w;
    ocol = idx % w;
    res.wall = nbhd[4];
    if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) begin
      cnt = $countones(nbhd);
      res.wall = (cnt > limit_reg) || (empty_wall_reg && cnt == 0);
    end
    res.last = (idx >= w * h - 1);
    if (res.last) begin
      nbhd         = '0;
      col_pos      = 0;
      feed_pos     = 0;
      frame_closed = 1'b1;
    end else begin
      feed_pos++;
    end
    return 1'b1;
  endfunction

  task automatic push_word(input logic kind, input logic wall, input row_check_t chk,
                           input cell_result_t want);
    int           gap;
    cell_result_t got;
    bit           has;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'b0, wall};
    do @(posedge clk); while (in_tready !== 1'b1);
    words_fed++;
    has = smooth_step(kind, wall, got);
    if (chk == CHK_TYPED) smoothed_due.push_back(want);
    else if (chk == CHK_PREDICTED && has) smoothed_due.push_back(got);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (smoothed_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no second assignment per edge.
  task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_WALL_LIMIT:    limit_reg      = val[3:0];
      REG_EMPTY_TO_WALL: empty_wall_reg = val[0];
      REG_GRID_WIDTH:    width_reg      = val;
      REG_GRID_HEIGHT:   height_reg     = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] lim, input logic e2w,
                               input logic [CFG_DATA_W-1:0] wd,
                               input logic [CFG_DATA_W-1:0] ht);
    wait_drained();
    cfg_word(REG_WALL_LIMIT, lim);
    cfg_word(REG_EMPTY_TO_WALL, {10'b0, e2w});
    cfg_word(REG_GRID_WIDTH, wd);
    cfg_word(REG_GRID_HEIGHT, ht);
    cfg_valid <= 1'b0;
  endtask

  // Grid cells with the given wall percentage; a few padding words act as floor.
  task automatic feed_cells(input int n, input int density);
    frame_closed = 1'b0;
    repeat (n) begin
      push_word(($urandom_range(0, 19) == 0) ? REQ_PADDING : REQ_CELL,
                $urandom_range(0, 99) < density, CHK_PREDICTED, '0);
    end
  endtask

  // Flushes the frame with padding, mixed with cell words whose values must not matter.
  task automatic drain_frame();
    while (!frame_closed) begin
      push_word(($urandom_range(0, 3) == 0) ? REQ_CELL : REQ_PADDING,
                1'($urandom_range(0, 1)), CHK_PREDICTED, '0);
    end
  endtask

  task automatic run_frame(input int density);
    feed_cells(clamp_dim(width_reg, DEFAULT_MAX_WIDTH) * clamp_dim(height_reg, DEFAULT_MAX_HEIGHT),
               density);
    drain_frame();
  endtask

  // The receiver switches between several stall patterns.
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (stall_tick % 4 != 0);
      default: out_tready <= (stall_tick % 23) >= 7;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (smoothed_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: wall=%0b last=%0b", out_tdata[0], out_tlast);
      end else begin
        head_cell = smoothed_due.pop_front();
        if (out_tdata[0] !== head_cell.wall || out_tlast !== head_cell.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected wall=%0b last=%0b, got wall=%0b last=%0b",
                     head_cell.wall, head_cell.last, out_tdata[0], out_tlast);
        end
      end
    end
  end

  initial begin
    int                    fed_mark;
    int                    density_pick [7];
    logic [CFG_DATA_W-1:0] lim, wd, ht;
    density_pick = '{0, 10, 30, 50, 70, 90, 100};
    limit_reg      = RST_WALL_LIMIT;
    empty_wall_reg = RST_EMPTY_TO_WALL;
    width_reg      = RST_GRID_WIDTH;
    height_reg     = RST_GRID_HEIGHT;
    nbhd           = '0;
    col_pos        = 0;
    feed_pos       = 0;
    frame_closed   = 1'b0;
    for (int i = 0; i < DEFAULT_MAX_WIDTH; i++) begin
      up_row[i]  = 1'b0;
      mid_row[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    load_settings(4, 1'b1, 3, 3);
    for (int i = 0; i < SEED_ROWS; i++)
      push_word(seed_rows[i].kind, seed_rows[i].wall, seed_rows[i].chk, seed_rows[i].want);

    // Width shrinks after three rows and six cells; the column counter has to wrap early.
    load_settings(4, 1'b1, 8, 8);
    feed_cells(30, 50);
    wait_drained();
    cfg_word(REG_GRID_WIDTH, 6);
    cfg_valid <= 1'b0;
    feed_cells(10, 50);
    drain_frame();

    // Height shrinks below the rows already streamed, so the next result closes the frame.
    load_settings(3, 1'b0, 6, 8);
    feed_cells(25, 50);
    wait_drained();
    cfg_word(REG_GRID_HEIGHT, 3);
    cfg_valid <= 1'b0;
    drain_frame();

    // A tall grid reached through clamping is cut short by lowering its height mid-frame.
    load_settings(9, 1'b1, 1, 2047);
    feed_cells(12, 50);
    wait_drained();
    cfg_word(REG_GRID_HEIGHT, 3);
    cfg_valid <= 1'b0;
    drain_frame();

    fed_mark = words_fed;
    while (words_fed - fed_mark < RANDOM_WORDS) begin
      lim = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 9 : 0)
                                        : CFG_DATA_W'($urandom_range(0, 9));
      wd  = CFG_DATA_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                    : $urandom_range(3, 10));
      ht  = CFG_DATA_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                    : $urandom_range(3, 7));
      load_settings(lim, 1'($urandom_range(0, 1)), wd, ht);
      run_frame(density_pick[$urandom_range(0, 6)]);
    end

    wait_drained();
    if (mismatches == 0 && smoothed_due.size() == 0)
      $display("cave_grid_smoothing_filter_test: PASS");
    else
      $display("cave_grid_smoothing_filter_test: FAIL");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("cave_grid_smoothing_filter_test: FAIL");
    $finish;
  end

endmodule
